[sv/rfas_pkg.sv]
// Package for the register file ALU step block.
// Holds word and index types, operation and command codes, reset values.
// No dependencies.
package rfas_pkg;

   localparam int unsigned WORD_W    = 16;
   localparam int unsigned NUM_REGS  = 8;
   localparam int unsigned REG_IDX_W = 3;
   localparam int unsigned SHAMT_W   = 4;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [REG_IDX_W-1:0] reg_idx_type;
   typedef logic [SHAMT_W-1:0]   shamt_type;

   typedef enum logic {
      CMD_EXEC = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_AND = 3'd2,
      OP_OR  = 3'd3,
      OP_XOR = 3'd4,
      OP_SHL = 3'd5,
      OP_SHR = 3'd6,
      OP_CMP = 3'd7
   } alu_op_type;

   // Compare outcomes as written to Rx
   localparam word_type CMP_EQ = 16'd0;
   localparam word_type CMP_GT = 16'd1;
   localparam word_type CMP_LT = 16'd2;

   localparam word_type REG_RESET [NUM_REGS] = '{
      16'hE013, 16'h1234, 16'hF79A, 16'h8012,
      16'h6345, 16'hABCD, 16'h7B23, 16'hABBB
   };

   // Instruction field extraction
   function automatic reg_idx_type instr_rx(input word_type instr);
      return instr[15:13];
   endfunction

   function automatic reg_idx_type instr_ry(input word_type instr);
      return instr[12:10];
   endfunction

   function automatic alu_op_type instr_op(input word_type instr);
      return alu_op_type'(instr[4:2]);
   endfunction

endpackage

[sv/register_file_alu_step.sv]
// Register file ALU step: eight 16-bit registers with an ALU in front of them.
// Depends on rfas_pkg and rfas_alu.
//
// The block takes one request beat per clock while req_stall is low and returns
// exactly one response beat per request, in order. A read (req_cmd = 1) returns
// the register named by req_reg_index; an execute (req_cmd = 0) decodes
// req_instruction (Rx in bits 15-13, Ry in bits 12-10, operation in bits 4-2),
// writes the ALU result back to Rx and returns it. Throughput is one beat per
// cycle while neither channel stalls. The request beat is captured into the
// operand stage when it is accepted and moves into the response register once
// that register is free, which raises rsp_valid; the response beat is then
// taken when rsp_stall is low. Back to back dependent instructions run at full
// rate: the result of the instruction in the operand stage is forwarded into
// the read of the next one. The registers hold their fixed reset values right
// out of reset: a per-register valid bit selects the reset constant until the
// first write, so no clearing pass is needed. req_stall rises only when the
// response register is full and rsp_stall is high.
module register_file_alu_step (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  rfas_pkg::word_type    req_instruction,
   input  rfas_pkg::reg_idx_type req_reg_index,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rfas_pkg::word_type    rsp_value
);
   import rfas_pkg::*;

   // ---------------------------------------------------------------------
   // Register file storage and valid bits
   // ---------------------------------------------------------------------
   word_type         reg_mem [NUM_REGS];
   logic [NUM_REGS-1:0] reg_vld_ff;
   logic [NUM_REGS-1:0] reg_vld_in;

   // ---------------------------------------------------------------------
   // Operand stage
   // ---------------------------------------------------------------------
   logic        s1_valid_ff, s1_valid_in;
   cmd_type     s1_cmd_ff;
   reg_idx_type s1_rx_ff;
   alu_op_type  s1_op_ff;
   word_type    s1_opa_ff;
   word_type    s1_opb_ff;

   // ---------------------------------------------------------------------
   // Response stage
   // ---------------------------------------------------------------------
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_value_ff;

   // Handshake and datapath controls
   logic        req_accept;
   logic        s1_adv;
   logic        s1_wr;
   logic        rsp_free;
   cmd_type     req_cmd_t;
   reg_idx_type rd_addr_a;
   reg_idx_type rd_addr_b;
   logic        fwd_a;
   logic        fwd_b;
   word_type    alu_res;
   word_type    s1_result;

   // The response register frees up when empty or when its beat is taken
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   // The operand stage moves on whenever the response register can take it
   assign s1_adv     = s1_valid_ff && rsp_free;
   assign req_stall  = s1_valid_ff && !rsp_free;
   assign req_accept = req_valid && !req_stall;

   // Execute beats write Rx as they leave the operand stage
   assign s1_wr = s1_adv && (s1_cmd_ff == CMD_EXEC);

   // Port A reads Rx for an execute, the named register for a read
   assign req_cmd_t = cmd_type'(req_cmd);
   assign rd_addr_a = (req_cmd_t == CMD_READ) ? req_reg_index : instr_rx(req_instruction);
   assign rd_addr_b = instr_ry(req_instruction);

   // Forward the writeback that lands on the same edge as this read
   assign fwd_a = s1_wr && (s1_rx_ff == rd_addr_a);
   assign fwd_b = s1_wr && (s1_rx_ff == rd_addr_b);

   rfas_alu u_alu (
      .opa    (s1_opa_ff),
      .opb    (s1_opb_ff),
      .op     (s1_op_ff),
      .result (alu_res)
   );

   assign s1_result = (s1_cmd_ff == CMD_READ) ? s1_opa_ff : alu_res;

   // ---------------------------------------------------------------------
   // Control next-state
   // ---------------------------------------------------------------------
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      reg_vld_in   = reg_vld_ff;

      // hold unless the stage drains or refills
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_wr) begin
         reg_vld_in[s1_rx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reg_vld_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         reg_vld_ff   <= reg_vld_in;
      end
   end

   // ---------------------------------------------------------------------
   // Register file write, registered reads and operand capture
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_wr) begin
         reg_mem[s1_rx_ff] <= alu_res;
      end

      if (req_accept) begin
         s1_cmd_ff <= req_cmd_t;
         s1_rx_ff  <= instr_rx(req_instruction);
         s1_op_ff  <= instr_op(req_instruction);
         // unwritten registers read as their reset value
         s1_opa_ff <= fwd_a ? alu_res :
                      reg_vld_ff[rd_addr_a] ? reg_mem[rd_addr_a] : REG_RESET[rd_addr_a];
         s1_opb_ff <= fwd_b ? alu_res :
                      reg_vld_ff[rd_addr_b] ? reg_mem[rd_addr_b] : REG_RESET[rd_addr_b];
      end
   end

   // Advance the result into the response register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_value_ff <= s1_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Backpressure on requests only ever comes from a stalled, full response
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("req_stall without response backpressure");

   // A stalled operand stage keeps its beat
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("operand stage lost a beat under stall");

   // A writeback marks its register as written
   a_wr_marks_valid: assert property (@(posedge clock) disable iff (reset)
      s1_wr |=> reg_vld_ff[$past(s1_rx_ff)])
      else $error("register valid bit not set after writeback");

   // A compare yields only equal, greater or less
   a_cmp_range: assert property (@(posedge clock) disable iff (reset)
      (s1_wr && (s1_op_ff == OP_CMP)) |=> (rsp_value_ff == CMP_EQ ||
         rsp_value_ff == CMP_GT || rsp_value_ff == CMP_LT))
      else $error("compare result out of range");

   // Every beat leaving the operand stage shows up as a response
   a_adv_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced beat missing from response register");

endmodule

[sv/rfas_alu.sv]
// Combinational ALU for the register file ALU step block.
// Depends on rfas_pkg for the word type and operation codes.
module rfas_alu (
   input  rfas_pkg::word_type   opa,
   input  rfas_pkg::word_type   opb,
   input  rfas_pkg::alu_op_type op,
   output rfas_pkg::word_type   result
);
   import rfas_pkg::*;

   shamt_type shamt;

   assign shamt = opb[SHAMT_W-1:0];

   always_comb begin
      unique case (op)
         OP_ADD: result = opa + opb;
         OP_SUB: result = opa - opb;
         OP_AND: result = opa & opb;
         OP_OR:  result = opa | opb;
         OP_XOR: result = opa ^ opb;
         OP_SHL: result = opa << shamt;
         OP_SHR: result = opa >> shamt;
         OP_CMP: begin
            if (opa == opb) begin
               result = CMP_EQ;
            end else if (opa > opb) begin
               result = CMP_GT;
            end else begin
               result = CMP_LT;
            end
         end
         default: result = CMP_EQ;
      endcase
   end

endmodule
